// ===== hdl/rtpd_pkg.sv =====
package rtpd_pkg;

    localparam int COUNT_BITS_DEF = 16;

    localparam int BYTE_W   = 8;
    localparam int RUN_W    = 16;
    localparam int STATUS_W = 2;
    localparam int OUT_DATA_W = BYTE_W + RUN_W;

    localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_QUOTE   = 8'h27;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_VT      = 8'h0B;
    localparam logic [BYTE_W-1:0] CH_FF      = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;

    localparam logic [2:0] SYM_TOKEN_LEN = 3'd3;
    localparam logic [2:0] LEN_CAP       = 3'd4;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_ZERO_CNT  = 2'd1;
    localparam t_status ST_BAD_SYM   = 2'd2;

    typedef struct packed {
        logic                emit;
        logic [BYTE_W-1:0]   symbol;
        logic [RUN_W-1:0]    run_length;
        t_status             status;
    } t_result;

endpackage

// ===== hdl/rtpd_parse.sv =====
module rtpd_parse #(
    parameter int COUNT_BITS = rtpd_pkg::COUNT_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_go,
    input  logic [rtpd_pkg::BYTE_W-1:0] i_byte,
    input  logic                      i_last,
    output rtpd_pkg::t_result         o_res
);
    import rtpd_pkg::*;

    logic                  r_phase, n_phase;
    logic [COUNT_BITS-1:0] r_accum, n_accum;
    logic                  r_started, n_started;
    logic                  r_ended, n_ended;
    logic [COUNT_BITS-1:0] r_held, n_held;
    logic [2:0]            r_len, n_len;
    logic [BYTE_W-1:0]     r_first, n_first;
    logic [BYTE_W-1:0]     r_middle, n_middle;
    logic [BYTE_W-1:0]     r_third, n_third;
    logic                  r_halted, n_halted;

    logic                  is_comma;
    logic                  is_nl;
    logic                  is_blank;
    logic                  is_digit;
    logic [COUNT_BITS+3:0] acc_ext;
    logic [COUNT_BITS+3:0] acc_mul;
    logic [COUNT_BITS-1:0] acc_sat;
    logic [COUNT_BITS+RUN_W-1:0] held_ext;
    logic [RUN_W-1:0]      run_sat;

    assign is_comma = (i_byte == CH_COMMA);
    assign is_nl    = (i_byte == CH_NEWLINE);
    assign is_blank = (i_byte == CH_SPACE) || (i_byte == CH_TAB) || (i_byte == CH_CR)
                   || (i_byte == CH_VT) || (i_byte == CH_FF);
    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);

    assign acc_ext = {4'b0, r_accum};
    assign acc_mul = (acc_ext << 3) + (acc_ext << 1)
                   + {{COUNT_BITS{1'b0}}, i_byte[3:0]};
    assign acc_sat = (acc_mul[COUNT_BITS+3:COUNT_BITS] != 4'b0) ? '1
                                                                 : acc_mul[COUNT_BITS-1:0];

    assign held_ext = {{RUN_W{1'b0}}, r_held};
    assign run_sat  = (held_ext > {{COUNT_BITS{1'b0}}, {RUN_W{1'b1}}}) ? '1
                                                                      : held_ext[RUN_W-1:0];

    always_comb begin
        n_phase   = r_phase;
        n_accum   = r_accum;
        n_started = r_started;
        n_ended   = r_ended;
        n_held    = r_held;
        n_len     = r_len;
        n_first   = r_first;
        n_middle  = r_middle;
        n_third   = r_third;
        n_halted  = r_halted;
        o_res     = '0;

        if (!r_halted) begin
            if (!is_comma && !is_nl) begin
                if (!r_phase) begin
                    if (!r_ended && !(!r_started && is_blank)) begin
                        n_started = 1'b1;
                        if (is_digit) begin
                            n_accum = acc_sat;
                        end else begin
                            n_ended = 1'b1;
                        end
                    end
                end else begin
                    case (r_len)
                        3'd0:    n_first  = i_byte;
                        3'd1:    n_middle = i_byte;
                        3'd2:    n_third  = i_byte;
                        default: ;
                    endcase
                    if (r_len < LEN_CAP) begin
                        n_len = r_len + 3'd1;
                    end
                end
            end

            if (is_comma || i_last) begin
                if (!r_phase) begin
                    if (n_accum == '0) begin
                        n_halted      = 1'b1;
                        o_res.emit    = 1'b1;
                        o_res.status  = ST_ZERO_CNT;
                    end else begin
                        n_held    = n_accum;
                        n_accum   = '0;
                        n_started = 1'b0;
                        n_ended   = 1'b0;
                        n_phase   = 1'b1;
                    end
                end else begin
                    n_phase = 1'b0;
                    if (n_len == SYM_TOKEN_LEN && n_first == CH_QUOTE && n_third == CH_QUOTE) begin
                        o_res.emit       = 1'b1;
                        o_res.status     = ST_OK;
                        o_res.symbol     = n_middle;
                        o_res.run_length = run_sat;
                        n_len    = '0;
                        n_first  = '0;
                        n_middle = '0;
                        n_third  = '0;
                    end else begin
                        n_halted     = 1'b1;
                        o_res.emit   = 1'b1;
                        o_res.status = ST_BAD_SYM;
                    end
                end
            end

            if (i_last && !n_halted) begin
                n_phase   = 1'b0;
                n_accum   = '0;
                n_started = 1'b0;
                n_ended   = 1'b0;
                n_held    = '0;
                n_len     = '0;
                n_first   = '0;
                n_middle  = '0;
                n_third   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= 1'b0;
            r_accum   <= '0;
            r_started <= 1'b0;
            r_ended   <= 1'b0;
            r_held    <= '0;
            r_len     <= '0;
            r_first   <= '0;
            r_middle  <= '0;
            r_third   <= '0;
            r_halted  <= 1'b0;
        end else if (i_go) begin
            r_phase   <= n_phase;
            r_accum   <= n_accum;
            r_started <= n_started;
            r_ended   <= n_ended;
            r_held    <= n_held;
            r_len     <= n_len;
            r_first   <= n_first;
            r_middle  <= n_middle;
            r_third   <= n_third;
            r_halted  <= n_halted;
        end
    end

endmodule

// ===== hdl/rle_text_pair_decoder_top.sv =====
// Path: the input transfer that completes a pair is held in the input register, and its result
// then passes to the result register. Throughput: one input byte per cycle; bytes that yield
// no result keep moving, but one that does stalls while an earlier result waits on i_m_tready.
// Reset: i_rst_n is synchronous, active low; it clears the parser state, the error
// halt and both valid flags.
module rle_text_pair_decoder_top #(
    parameter int COUNT_BITS = rtpd_pkg::COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [7:0]                      i_s_tdata,  // [7:0] byte_req
    input  logic                            i_s_tlast,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [rtpd_pkg::OUT_DATA_W-1:0] o_m_tdata,  // [7:0] symbol, [23:8] run_length
    output logic [rtpd_pkg::STATUS_W-1:0]   o_m_tuser   // [1:0] status
);
    import rtpd_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic              r_out_valid;
    t_result           r_out;
    t_result           step_res;
    logic              go;

    assign go         = r_in_valid && (!step_res.emit || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || go;

    rtpd_parse #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && step_res.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && step_res.emit) begin
            r_out <= step_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.run_length, r_out.symbol};
    assign o_m_tuser  = r_out.status;

endmodule

// ===== hdl/rtpd_checker.sv =====
module rtpd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [rtpd_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input logic [rtpd_pkg::STATUS_W-1:0]   o_m_tuser
);
    import rtpd_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    a_error_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != ST_OK |-> o_m_tdata == '0)
        else $error("error result carries payload");

    a_halt_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && o_m_tuser != ST_OK |=> !o_m_tvalid)
        else $error("result after error");

    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == ST_OK |-> o_m_tdata[OUT_DATA_W-1:BYTE_W] != '0)
        else $error("pair with zero run length");

endmodule

bind rle_text_pair_decoder_top rtpd_checker u_rtpd_checker (.*);
